[hw/rtl/qvr_pkg.sv]
// ----------------------------------------------------------------------------
// qvr_pkg
// Shared widths and configuration register codes for the quaternion rotator.
// ----------------------------------------------------------------------------
package qvr_pkg;

  // Quaternion register width (Q2.14 at the default fraction width)
  localparam int QREG_W = 16;
  // Rotated component width, saturated
  localparam int OUT_W  = 18;
  // Configuration index width
  localparam int CFG_IDX_W = 2;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_QUAT_W = 2'd0;
  localparam cfg_idx_t CFG_QUAT_X = 2'd1;
  localparam cfg_idx_t CFG_QUAT_Y = 2'd2;
  localparam cfg_idx_t CFG_QUAT_Z = 2'd3;

endpackage

[hw/rtl/qvr_vec_if.sv]
// ----------------------------------------------------------------------------
// qvr_vec_if
// Input vector channel: valid/ready handshake carrying one 3-component item.
// ----------------------------------------------------------------------------
interface qvr_vec_if #(
  parameter int VEC_WIDTH = 16
) ();

  logic                        valid;
  logic                        ready;
  logic signed [VEC_WIDTH-1:0] vec_x;
  logic signed [VEC_WIDTH-1:0] vec_y;
  logic signed [VEC_WIDTH-1:0] vec_z;

  modport source (output valid, output vec_x, output vec_y, output vec_z, input ready);
  modport sink   (input valid, input vec_x, input vec_y, input vec_z, output ready);

endinterface

[hw/rtl/qvr_rot_if.sv]
// ----------------------------------------------------------------------------
// qvr_rot_if
// Result channel: valid/ready handshake carrying the rotated vector and a
// saturation flag.
// ----------------------------------------------------------------------------
interface qvr_rot_if import qvr_pkg::*; ();

  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] rot_x;
  logic signed [OUT_W-1:0] rot_y;
  logic signed [OUT_W-1:0] rot_z;
  logic                    saturated;

  modport source (output valid, output rot_x, output rot_y, output rot_z,
                  output saturated, input ready);
  modport sink   (input valid, input rot_x, input rot_y, input rot_z,
                  input saturated, output ready);

endinterface

[hw/rtl/quaternion_vector_rotate.sv]
// ----------------------------------------------------------------------------
// quaternion_vector_rotate
// Rotates each input vector by the configured quaternion through a
// four-stage multiplier pipeline.
// ----------------------------------------------------------------------------
// Takes one vector item per clock and returns one rotated item per clock
// while the output is not stalled. A result is on the output once its
// vector has passed four registers, the accepting edge loading the first
// (stage 1 squares/cross products of the quaternion, stage 2 rounded
// rotation matrix entries, stage 3 nine entry*component products, stage 4
// row sums, rounding and saturation into the output register). Each
// stage holds its own valid bit and advances when it is empty or the stage
// after it advances, so bubbles are squeezed out and a stalled output only
// backs up the stages behind it. The matrix is rebuilt for every item from
// the quaternion registers, so a configuration write is seen by the very
// next item. The quaternion is not normalized: matrix entries are used as
// computed, and any component outside signed 18 bits is clipped with the
// saturated flag set. Rounding is half up (toward plus infinity) for both the
// matrix entries and the final components.
module quaternion_vector_rotate import qvr_pkg::*; #(
  parameter int VEC_WIDTH      = 16,
  parameter int QUAT_FRAC_BITS = 14
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration write port
  input  logic              cfg_we_i,
  input  cfg_idx_t          cfg_idx_i,
  input  logic [QREG_W-1:0] cfg_wdata_i,
  // item channels
  qvr_vec_if.sink           vec_i,
  qvr_rot_if.source         rot_o
);

  // Exact quaternion product width and matrix entry width (2F fraction bits)
  localparam int QP_W = 2 * QREG_W;
  localparam int EW   = (2 * QUAT_FRAC_BITS + 2 > QP_W + 2) ?
                        (2 * QUAT_FRAC_BITS + 2) : (QP_W + 2);
  // Rounded entry (F fraction bits), entry*component product, row sum
  localparam int RW   = EW - QUAT_FRAC_BITS;
  localparam int PW   = RW + VEC_WIDTH;
  localparam int SW   = (PW + 2 > OUT_W + 1) ? (PW + 2) : (OUT_W + 1);

  localparam logic signed [EW-1:0] ONE_E  =
    {{(EW-1){1'b0}}, 1'b1} << (2 * QUAT_FRAC_BITS);
  localparam logic signed [EW-1:0] HALF_E =
    {{(EW-1){1'b0}}, 1'b1} << (QUAT_FRAC_BITS - 1);
  localparam logic signed [SW-1:0] HALF_S =
    {{(SW-1){1'b0}}, 1'b1} << (QUAT_FRAC_BITS - 1);
  localparam logic signed [SW-1:0] OUT_MAX_S =
    ({{(SW-1){1'b0}}, 1'b1} << (OUT_W - 1)) - {{(SW-1){1'b0}}, 1'b1};
  localparam logic signed [SW-1:0] OUT_MIN_S = -({{(SW-1){1'b0}}, 1'b1} << (OUT_W - 1));
  localparam logic signed [OUT_W-1:0] OUT_MAX = OUT_MAX_S[OUT_W-1:0];
  localparam logic signed [OUT_W-1:0] OUT_MIN = OUT_MIN_S[OUT_W-1:0];
  localparam logic [QREG_W-1:0] QW_RESET =
    {{(QREG_W-1){1'b0}}, 1'b1} << QUAT_FRAC_BITS;

  // round 2F fraction bits to F, half up
  function automatic logic signed [RW-1:0] entry_rnd(input logic signed [EW-1:0] e);
    logic signed [EW-1:0] t;
    t = e + HALF_E;
    return t[EW-1:QUAT_FRAC_BITS];
  endfunction

  // --------------------------------------------------------------------------
  // Quaternion registers
  // --------------------------------------------------------------------------
  logic signed [QREG_W-1:0] qw_q, qx_q, qy_q, qz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qw_q <= QW_RESET;
      qx_q <= '0;
      qy_q <= '0;
      qz_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_QUAT_W: qw_q <= cfg_wdata_i;
        CFG_QUAT_X: qx_q <= cfg_wdata_i;
        CFG_QUAT_Y: qy_q <= cfg_wdata_i;
        CFG_QUAT_Z: qz_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Stage flow control
  // --------------------------------------------------------------------------
  logic v1_q, v2_q, v3_q, v4_q;
  logic adv1, adv2, adv3, adv4;

  assign adv4 = !v4_q || rot_o.ready;
  assign adv3 = !v3_q || adv4;
  assign adv2 = !v2_q || adv3;
  assign adv1 = !v1_q || adv2;

  assign vec_i.ready = adv1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= vec_i.valid;
      if (adv2) v2_q <= v1_q;
      if (adv3) v3_q <= v2_q;
      if (adv4) v4_q <= v3_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: quaternion products
  // --------------------------------------------------------------------------
  logic signed [QP_W-1:0]      xx_q, yy_q, zz_q, xy_q, xz_q, yz_q, xw_q, yw_q, zw_q;
  logic signed [VEC_WIDTH-1:0] vec1_q [3];

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      xx_q      <= qx_q * qx_q;
      yy_q      <= qy_q * qy_q;
      zz_q      <= qz_q * qz_q;
      xy_q      <= qx_q * qy_q;
      xz_q      <= qx_q * qz_q;
      yz_q      <= qy_q * qz_q;
      xw_q      <= qx_q * qw_q;
      yw_q      <= qy_q * qw_q;
      zw_q      <= qz_q * qw_q;
      vec1_q[0] <= vec_i.vec_x;
      vec1_q[1] <= vec_i.vec_y;
      vec1_q[2] <= vec_i.vec_z;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: rounded matrix entries, row major
  // --------------------------------------------------------------------------
  logic signed [EW-1:0]        exx, eyy, ezz, exy, exz, eyz, exw, eyw, ezw;
  logic signed [EW-1:0]        ent [9];
  logic signed [RW-1:0]        m_q [9];
  logic signed [VEC_WIDTH-1:0] vec2_q [3];

  assign exx = EW'(xx_q);
  assign eyy = EW'(yy_q);
  assign ezz = EW'(zz_q);
  assign exy = EW'(xy_q);
  assign exz = EW'(xz_q);
  assign eyz = EW'(yz_q);
  assign exw = EW'(xw_q);
  assign eyw = EW'(yw_q);
  assign ezw = EW'(zw_q);

  always_comb begin
    ent[0] = ONE_E - ((eyy + ezz) <<< 1);
    ent[1] = (exy - ezw) <<< 1;
    ent[2] = (exz + eyw) <<< 1;
    ent[3] = (exy + ezw) <<< 1;
    ent[4] = ONE_E - ((exx + ezz) <<< 1);
    ent[5] = (eyz - exw) <<< 1;
    ent[6] = (exz - eyw) <<< 1;
    ent[7] = (eyz + exw) <<< 1;
    ent[8] = ONE_E - ((exx + eyy) <<< 1);
  end

  always_ff @(posedge clk_i) begin
    if (adv2) begin
      for (int i = 0; i < 9; i++) begin
        m_q[i] <= entry_rnd(ent[i]);
      end
      vec2_q <= vec1_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: entry * component products
  // --------------------------------------------------------------------------
  logic signed [PW-1:0] prod_q [9];

  always_ff @(posedge clk_i) begin
    if (adv3) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod_q[3*r+c] <= m_q[3*r+c] * vec2_q[c];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: row sums, round half up, saturate
  // --------------------------------------------------------------------------
  logic signed [SW-1:0]    sum   [3];
  logic signed [SW-1:0]    shr   [3];
  logic signed [OUT_W-1:0] rot_d [3];
  logic [2:0]              clip;
  logic signed [OUT_W-1:0] rot_q [3];
  logic                    sat_q;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sum[r] = SW'(prod_q[3*r]) + SW'(prod_q[3*r+1]) + SW'(prod_q[3*r+2]) + HALF_S;
      shr[r] = sum[r] >>> QUAT_FRAC_BITS;
      if (shr[r] > OUT_MAX_S) begin
        rot_d[r] = OUT_MAX;
        clip[r]  = 1'b1;
      end else if (shr[r] < OUT_MIN_S) begin
        rot_d[r] = OUT_MIN;
        clip[r]  = 1'b1;
      end else begin
        rot_d[r] = shr[r][OUT_W-1:0];
        clip[r]  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv4) begin
      rot_q <= rot_d;
      sat_q <= |clip;
    end
  end

  assign rot_o.valid     = v4_q;
  assign rot_o.rot_x     = rot_q[0];
  assign rot_o.rot_y     = rot_q[1];
  assign rot_o.rot_z     = rot_q[2];
  assign rot_o.saturated = sat_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // an accepted item lands in stage 1
  a_accept_to_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vec_i.valid && vec_i.ready |=> v1_q)
    else $error("accepted item missing from stage 1");

  // a full stage behind a stalled output keeps its item
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q && v4_q && !rot_o.ready |=> v3_q && v4_q)
    else $error("item lost while output stalled");

  // the flag only comes with a component sitting on a rail
  a_sat_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rot_o.valid && rot_o.saturated |->
      (rot_o.rot_x == OUT_MAX) || (rot_o.rot_x == OUT_MIN) ||
      (rot_o.rot_y == OUT_MAX) || (rot_o.rot_y == OUT_MIN) ||
      (rot_o.rot_z == OUT_MAX) || (rot_o.rot_z == OUT_MIN))
    else $error("saturated set without a clipped component");

endmodule
